// File: hdl/segint_pkg.sv
// segint_pkg: shared constants for the segment intersection block
// no dependencies
`default_nettype none

package segint_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF   = 8;
    localparam int OUT_W           = 24;
    localparam int OUT_DATA_W      = 2 * OUT_W;
    localparam int NUM_COORDS      = 8;

endpackage

`default_nettype wire

// File: hdl/segint_front.sv
// segint_front: differences, cross products, hit test and scaled numerators
// depends on segint_pkg
`default_nettype none

module segint_front #(
    parameter int COORD_WIDTH = 16,
    parameter int FRAC_BITS   = 8,
    localparam int DW = COORD_WIDTH + 1,
    localparam int PW = 2 * DW,
    localparam int XW = PW + 1,
    localparam int TW = XW - 1,
    localparam int NW = TW + COORD_WIDTH + FRAC_BITS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [8*COORD_WIDTH-1:0]      i_coords,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [NW-1:0]                      o_num_x,
    output logic [NW-1:0]                      o_num_y,
    output logic [TW-1:0]                      o_den,
    output logic                               o_neg_x,
    output logic                               o_neg_y,
    output logic                               o_hit,
    output logic signed [COORD_WIDTH-1:0]      o_start_x,
    output logic signed [COORD_WIDTH-1:0]      o_start_y
);
    import segint_pkg::*;

    localparam int CW = COORD_WIDTH;

    logic signed [CW-1:0] w_px, w_py, w_ex, w_ey, w_qx, w_qy, w_fx, w_fy;
    logic r_v1, r_v2, r_v3, r_v4;
    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4;

    logic signed [DW-1:0] r1_rx, r1_ry, r1_sx, r1_sy, r1_dx, r1_dy;
    logic signed [CW-1:0] r1_px, r1_py;
    logic signed [PW-1:0] r2_p0, r2_p1, r2_p2, r2_p3, r2_p4, r2_p5;
    logic signed [DW-1:0] r2_rx, r2_ry;
    logic signed [CW-1:0] r2_px, r2_py;
    logic signed [XW-1:0] w_den, w_tn, w_un, w_denn, w_tnn, w_unn;
    logic signed [DW-1:0] w_arx, w_ary;
    logic                 w_hit;
    logic [TW-1:0]        r3_tn, r3_den;
    logic [CW-1:0]        r3_mx, r3_my;
    logic                 r3_nx, r3_ny, r3_hit;
    logic signed [CW-1:0] r3_px, r3_py;
    logic [NW-1:0]        r4_nx, r4_ny;
    logic [TW-1:0]        r4_den;
    logic                 r4_nx_s, r4_ny_s, r4_hit;
    logic signed [CW-1:0] r4_px, r4_py;

    assign w_px = i_coords[0*CW +: CW];
    assign w_py = i_coords[1*CW +: CW];
    assign w_ex = i_coords[2*CW +: CW];
    assign w_ey = i_coords[3*CW +: CW];
    assign w_qx = i_coords[4*CW +: CW];
    assign w_qy = i_coords[5*CW +: CW];
    assign w_fx = i_coords[6*CW +: CW];
    assign w_fy = i_coords[7*CW +: CW];

    assign w_rdy4  = !r_v4 || i_ready;
    assign w_rdy3  = !r_v3 || w_rdy4;
    assign w_rdy2  = !r_v2 || w_rdy3;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign o_ready = w_rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_valid;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
            if (w_rdy4) r_v4 <= r_v3;
        end
    end

    // direction and start difference vectors
    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r1_rx <= DW'(w_ex) - DW'(w_px);
            r1_ry <= DW'(w_ey) - DW'(w_py);
            r1_sx <= DW'(w_fx) - DW'(w_qx);
            r1_sy <= DW'(w_fy) - DW'(w_qy);
            r1_dx <= DW'(w_qx) - DW'(w_px);
            r1_dy <= DW'(w_qy) - DW'(w_py);
            r1_px <= w_px;
            r1_py <= w_py;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy2) begin
            r2_p0 <= r1_rx * r1_sy;
            r2_p1 <= r1_ry * r1_sx;
            r2_p2 <= r1_dx * r1_sy;
            r2_p3 <= r1_dy * r1_sx;
            r2_p4 <= r1_dx * r1_ry;
            r2_p5 <= r1_dy * r1_rx;
            r2_rx <= r1_rx;
            r2_ry <= r1_ry;
            r2_px <= r1_px;
            r2_py <= r1_py;
        end
    end

    // cross products, sign normalization and range test
    always_comb begin
        w_den  = XW'(r2_p0) - XW'(r2_p1);
        w_tn   = XW'(r2_p2) - XW'(r2_p3);
        w_un   = XW'(r2_p4) - XW'(r2_p5);
        w_denn = w_den[XW-1] ? -w_den : w_den;
        w_tnn  = w_den[XW-1] ? -w_tn  : w_tn;
        w_unn  = w_den[XW-1] ? -w_un  : w_un;
        w_hit  = (w_den != '0) && !w_tnn[XW-1] && !w_unn[XW-1]
                 && (w_tnn <= w_denn) && (w_unn <= w_denn);
        w_arx  = r2_rx[DW-1] ? -r2_rx : r2_rx;
        w_ary  = r2_ry[DW-1] ? -r2_ry : r2_ry;
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy3) begin
            r3_tn  <= w_tnn[TW-1:0];
            r3_den <= w_denn[TW-1:0];
            r3_mx  <= w_arx[CW-1:0];
            r3_my  <= w_ary[CW-1:0];
            r3_nx  <= r2_rx[DW-1];
            r3_ny  <= r2_ry[DW-1];
            r3_hit <= w_hit;
            r3_px  <= r2_px;
            r3_py  <= r2_py;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy4) begin
            r4_nx   <= (NW'(r3_tn) * NW'(r3_mx)) << FRAC_BITS;
            r4_ny   <= (NW'(r3_tn) * NW'(r3_my)) << FRAC_BITS;
            r4_den  <= r3_den;
            r4_nx_s <= r3_nx;
            r4_ny_s <= r3_ny;
            r4_hit  <= r3_hit;
            r4_px   <= r3_px;
            r4_py   <= r3_py;
        end
    end

    assign o_valid   = r_v4;
    assign o_num_x   = r4_nx;
    assign o_num_y   = r4_ny;
    assign o_den     = r4_den;
    assign o_neg_x   = r4_nx_s;
    assign o_neg_y   = r4_ny_s;
    assign o_hit     = r4_hit;
    assign o_start_x = r4_px;
    assign o_start_y = r4_py;

endmodule

`default_nettype wire

// File: hdl/segint_div_cell.sv
// segint_div_cell: one quotient bit of the x and y divisions per cell
// depends on segint_pkg
`default_nettype none

module segint_div_cell #(
    parameter int NW    = 60,
    parameter int TW    = 34,
    parameter int QW    = 24,
    parameter int CW    = 16,
    parameter int SHIFT = 0
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic [NW-1:0]        i_rem_x,
    input  wire logic [NW-1:0]        i_rem_y,
    input  wire logic [TW-1:0]        i_den,
    input  wire logic [QW-1:0]        i_q_x,
    input  wire logic [QW-1:0]        i_q_y,
    input  wire logic [3:0]           i_flags,
    input  wire logic [2*CW-1:0]      i_start,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic [NW-1:0]             o_rem_x,
    output logic [NW-1:0]             o_rem_y,
    output logic [TW-1:0]             o_den,
    output logic [QW-1:0]             o_q_x,
    output logic [QW-1:0]             o_q_y,
    output logic [3:0]                o_flags,
    output logic [2*CW-1:0]           o_start
);
    import segint_pkg::*;

    logic          r_valid;
    logic [NW-1:0] w_dsh;
    logic          w_ge_x, w_ge_y;

    assign o_ready = !r_valid || i_ready;
    assign w_dsh   = NW'(i_den) << SHIFT;
    assign w_ge_x  = i_rem_x >= w_dsh;
    assign w_ge_y  = i_rem_y >= w_dsh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            o_rem_x <= w_ge_x ? i_rem_x - w_dsh : i_rem_x;
            o_rem_y <= w_ge_y ? i_rem_y - w_dsh : i_rem_y;
            o_q_x   <= {i_q_x[QW-2:0], w_ge_x};
            o_q_y   <= {i_q_y[QW-2:0], w_ge_y};
            o_den   <= i_den;
            o_flags <= i_flags;
            o_start <= i_start;
        end
    end

    assign o_valid = r_valid;

endmodule

`default_nettype wire

// File: hdl/segint_back.sv
// segint_back: adds the signed offsets to the start point, output register
// depends on segint_pkg
`default_nettype none

module segint_back #(
    parameter int COORD_WIDTH = 16,
    parameter int FRAC_BITS   = 8,
    localparam int QW = COORD_WIDTH + FRAC_BITS,
    localparam int SW = QW + 2,
    localparam int EW = (SW > segint_pkg::OUT_W) ? SW : segint_pkg::OUT_W
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [QW-1:0]                 i_q_x,
    input  wire logic [QW-1:0]                 i_q_y,
    input  wire logic                          i_neg_x,
    input  wire logic                          i_neg_y,
    input  wire logic                          i_hit,
    input  wire logic signed [COORD_WIDTH-1:0] i_start_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_start_y,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic                               o_hit,
    output logic [segint_pkg::OUT_W-1:0]       o_hit_x,
    output logic [segint_pkg::OUT_W-1:0]       o_hit_y
);
    import segint_pkg::*;

    logic                 r_valid;
    logic signed [EW-1:0] w_qx, w_qy, w_sum_x, w_sum_y;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        w_qx    = EW'($signed({1'b0, i_q_x}));
        w_qy    = EW'($signed({1'b0, i_q_y}));
        w_sum_x = (EW'(i_start_x) <<< FRAC_BITS) + (i_neg_x ? -w_qx : w_qx);
        w_sum_y = (EW'(i_start_y) <<< FRAC_BITS) + (i_neg_y ? -w_qy : w_qy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            o_hit   <= i_hit;
            o_hit_x <= i_hit ? w_sum_x[OUT_W-1:0] : '0;
            o_hit_y <= i_hit ? w_sum_y[OUT_W-1:0] : '0;
        end
    end

    assign o_valid = r_valid;

endmodule

`default_nettype wire

// File: hdl/segment_intersection_2d_top.sv
// segment_intersection_2d_top: 2d segment intersection, fixed point result
// depends on segint_pkg, segint_front, segint_div_cell, segint_back
`default_nettype none

// Takes one segment pair per cycle while not stalled and returns one item per pair: the
// hit flag and the intersection point with FRAC_BITS fraction bits. The pipeline is
// four front stages for differences, cross products, hit test and numerator scaling, one
// cell per quotient bit in the restoring divider chain, and the output register.
// Every stage holds on downstream stall; without a stall, throughput is one item per cycle.

module segment_intersection_2d_top #(
    parameter int COORD_WIDTH = segint_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = segint_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_s_axis_tvalid,
    output logic                                     o_s_axis_tready,
    // a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y, b_end_x, b_end_y
    input  wire logic [8*COORD_WIDTH-1:0]            i_s_axis_tdata,
    output logic                                     o_m_axis_tvalid,
    input  wire logic                                i_m_axis_tready,
    // hit_x, hit_y
    output logic [segint_pkg::OUT_DATA_W-1:0]        o_m_axis_tdata,
    // hit
    output logic                                     o_m_axis_tuser
);
    import segint_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int DW = CW + 1;
    localparam int TW = 2 * DW;
    localparam int QW = CW + FRAC_BITS;
    localparam int NW = TW + QW;

    logic          c_valid [0:QW];
    logic          c_ready [0:QW];
    logic [NW-1:0] c_rem_x [0:QW];
    logic [NW-1:0] c_rem_y [0:QW];
    logic [TW-1:0] c_den   [0:QW];
    logic [QW-1:0] c_q_x   [0:QW];
    logic [QW-1:0] c_q_y   [0:QW];
    logic [3:0]    c_flags [0:QW];
    logic [2*CW-1:0] c_start [0:QW];

    logic signed [CW-1:0] w_sx, w_sy;
    logic                 w_neg_x, w_neg_y, w_hit;
    logic [OUT_W-1:0]     w_hx, w_hy;

    segint_front #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_coords  (i_s_axis_tdata),
        .o_valid   (c_valid[0]),
        .i_ready   (c_ready[0]),
        .o_num_x   (c_rem_x[0]),
        .o_num_y   (c_rem_y[0]),
        .o_den     (c_den[0]),
        .o_neg_x   (w_neg_x),
        .o_neg_y   (w_neg_y),
        .o_hit     (w_hit),
        .o_start_x (w_sx),
        .o_start_y (w_sy)
    );

    assign c_q_x[0]   = '0;
    assign c_q_y[0]   = '0;
    assign c_flags[0] = {1'b0, w_hit, w_neg_y, w_neg_x};
    assign c_start[0] = {w_sy, w_sx};

    for (genvar j = 0; j < QW; j++) begin : g_cell
        segint_div_cell #(
            .NW    (NW),
            .TW    (TW),
            .QW    (QW),
            .CW    (CW),
            .SHIFT (QW - 1 - j)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (c_valid[j]),
            .o_ready (c_ready[j]),
            .i_rem_x (c_rem_x[j]),
            .i_rem_y (c_rem_y[j]),
            .i_den   (c_den[j]),
            .i_q_x   (c_q_x[j]),
            .i_q_y   (c_q_y[j]),
            .i_flags (c_flags[j]),
            .i_start (c_start[j]),
            .o_valid (c_valid[j+1]),
            .i_ready (c_ready[j+1]),
            .o_rem_x (c_rem_x[j+1]),
            .o_rem_y (c_rem_y[j+1]),
            .o_den   (c_den[j+1]),
            .o_q_x   (c_q_x[j+1]),
            .o_q_y   (c_q_y[j+1]),
            .o_flags (c_flags[j+1]),
            .o_start (c_start[j+1])
        );
    end

    segint_back #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (c_valid[QW]),
        .o_ready   (c_ready[QW]),
        .i_q_x     (c_q_x[QW]),
        .i_q_y     (c_q_y[QW]),
        .i_neg_x   (c_flags[QW][0]),
        .i_neg_y   (c_flags[QW][1]),
        .i_hit     (c_flags[QW][2] & ~c_flags[QW][3]),
        .i_start_x (c_start[QW][CW-1:0]),
        .i_start_y (c_start[QW][2*CW-1:CW]),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_hit     (o_m_axis_tuser),
        .o_hit_x   (w_hx),
        .o_hit_y   (w_hy)
    );

    assign o_m_axis_tdata = {w_hy, w_hx};

endmodule

`default_nettype wire

// File: hdl/segint_chk.sv
// segint_chk: port level checks on the segment intersection top level
// depends on segint_pkg; bound to segment_intersection_2d_top
`default_nettype none

module segint_chk (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              o_s_axis_tready,
    input wire logic                              o_m_axis_tvalid,
    input wire logic                              i_m_axis_tready,
    input wire logic [segint_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    input wire logic                              o_m_axis_tuser
);
    import segint_pkg::*;

    // stalled item holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
        o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("output item changed under stall");

    // no hit means zero point
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser |-> o_m_axis_tdata == '0)
        else $error("nonzero point without hit");

    // pipeline empty after reset
    a_rst_out: assert property (@(posedge i_clk)
        i_rst_n && $past(!i_rst_n) |-> !o_m_axis_tvalid)
        else $error("output valid right after reset");

    a_rst_in: assert property (@(posedge i_clk)
        i_rst_n && $past(!i_rst_n) |-> o_s_axis_tready)
        else $error("input not ready right after reset");

endmodule

bind segment_intersection_2d_top segint_chk u_segint_chk (.*);

`default_nettype wire

// File: test/tb_segment_intersection_2d_top.sv
// tb_segment_intersection_2d_top: checks segment pair intersection hit flag and fixed point point
// depends on segint_pkg and segment_intersection_2d_top; predicts each item and compares in order
`default_nettype none

class segint_scoreboard;
    logic [47:0] exp_data_q[$];
    logic        exp_hit_q[$];
    int          n_errors;
    int          n_checked;
    int          n_hits;

    function new();
        n_errors  = 0;
        n_checked = 0;
        n_hits    = 0;
    endfunction

    static function logic [23:0] axis_point(logic signed [15:0] start, logic signed [16:0] dir,
                                            logic signed [63:0] tn, logic signed [63:0] den);
        logic [127:0] prod;
        logic [127:0] q;
        logic [16:0]  mag;
        logic [23:0]  base;
        mag  = dir[16] ? -dir : dir;
        prod = (128'(tn) * 128'(mag)) << 8;
        q    = prod / 128'(den);
        base = 24'(start) << 8;
        return dir[16] ? base - q[23:0] : base + q[23:0];
    endfunction

    function void note_pair(logic [127:0] pair);
        logic signed [15:0] px, py, ex, ey, qx, qy, fx, fy;
        logic signed [16:0] rx, ry, sx, sy, dx, dy;
        logic signed [63:0] den, tn, un;
        logic               hit;
        logic [23:0]        hx, hy;
        px = pair[15:0];    py = pair[31:16];
        ex = pair[47:32];   ey = pair[63:48];
        qx = pair[79:64];   qy = pair[95:80];
        fx = pair[111:96];  fy = pair[127:112];
        rx = ex - px;  ry = ey - py;
        sx = fx - qx;  sy = fy - qy;
        dx = qx - px;  dy = qy - py;
        den = 64'(rx) * 64'(sy) - 64'(ry) * 64'(sx);
        tn  = 64'(dx) * 64'(sy) - 64'(dy) * 64'(sx);
        un  = 64'(dx) * 64'(ry) - 64'(dy) * 64'(rx);
        hit = 1'b0;
        if (den != 0) begin
            if (den < 0) begin
                den = -den;
                tn  = -tn;
                un  = -un;
            end
            hit = (tn >= 0) && (un >= 0) && (tn <= den) && (un <= den);
        end
        hx = hit ? axis_point(px, rx, tn, den) : 24'd0;
        hy = hit ? axis_point(py, ry, tn, den) : 24'd0;
        exp_data_q.push_back({hy, hx});
        exp_hit_q.push_back(hit);
    endfunction

    task report(string what, logic [47:0] got, logic [47:0] want);
        n_errors++;
        $display("mismatch %s: got %h expected %h", what, got, want);
    endtask

    task check_result(logic [47:0] data, logic hit);
        logic [47:0] ed;
        logic        eh;
        if (exp_hit_q.size() == 0) begin
            report("unexpected item", data, 48'd0);
        end else begin
            ed = exp_data_q.pop_front();
            eh = exp_hit_q.pop_front();
            n_checked++;
            if (eh) n_hits++;
            if (hit !== eh) report("hit", 48'(hit), 48'(eh));
            if (data[23:0] !== ed[23:0]) report("hit_x", 48'(data[23:0]), 48'(ed[23:0]));
            if (data[47:24] !== ed[47:24]) report("hit_y", 48'(data[47:24]), 48'(ed[47:24]));
        end
    endtask
endclass

module tb_segment_intersection_2d_top;
    import segint_pkg::*;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [127:0]          in_data = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [OUT_DATA_W-1:0] out_data;
    logic                  out_hit;
    logic                  hold_off = 1'b0;
    segint_scoreboard      sb;
    logic [127:0]          pair_q[$];
    int                    n_sent;

    always #5 clk = ~clk;

    segment_intersection_2d_top dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (in_valid),
        .o_s_axis_tready (in_ready),
        .i_s_axis_tdata  (in_data),
        .o_m_axis_tvalid (out_valid),
        .i_m_axis_tready (out_ready),
        .o_m_axis_tdata  (out_data),
        .o_m_axis_tuser  (out_hit)
    );

    function automatic logic [15:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($urandom_range(0, 40) - 20);
            default: return 16'($urandom);
        endcase
    endfunction

    // crossing pair: b passes through a point on a
    function automatic logic [127:0] crossing_pair();
        int cx, cy, ax, ay, bx, by, span;
        span = ($urandom_range(0, 9) == 0) ? 16000 : 200;
        cx = int'($urandom_range(0, 2 * span)) - span;
        cy = int'($urandom_range(0, 2 * span)) - span;
        ax = int'($urandom_range(0, 2 * span)) - span;
        ay = int'($urandom_range(0, 2 * span)) - span;
        bx = int'($urandom_range(0, 2 * span)) - span;
        by = int'($urandom_range(0, 2 * span)) - span;
        return {16'(cy + by), 16'(cx + bx), 16'(cy - by), 16'(cx - bx),
                16'(cy + ay), 16'(cx + ax), 16'(cy - ay), 16'(cx - ax)};
    endfunction

    function automatic logic [127:0] random_pair();
        logic [127:0] p;
        for (int i = 0; i < 8; i++) p[16*i +: 16] = rand_coord();
        return p;
    endfunction

    task send_pair(logic [127:0] p);
        in_valid <= 1'b1;
        in_data  <= p;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_pair(p);
        n_sent++;
    endtask

    task send_gap();
        in_valid <= 1'b0;
        in_data  <= 128'($urandom) << 64;
        repeat ($urandom_range(1, 6)) @(posedge clk);
    endtask

    task wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.exp_hit_q.size() != 0) @(posedge clk);
    endtask

    // receiver stall pattern, with a long hold-off on request
    initial begin
        int mode;
        mode = 0;
        forever begin
            @(posedge clk);
            if (hold_off) out_ready <= 1'b0;
            else if (mode == 0) out_ready <= 1'b1;
            else if (mode == 1) out_ready <= ($urandom_range(0, 3) != 0);
            else out_ready <= ($urandom_range(0, 1) == 0);
            if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 2);
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) sb.check_result(out_data, out_hit);
    end

    initial begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        sb = new();
        n_sent = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, parallel, collinear, endpoints touching, cross
        pair_q.push_back({8{16'h0000}});
        pair_q.push_back({8{16'h8000}});
        pair_q.push_back({8{16'h7fff}});
        pair_q.push_back({16'h7fff, 16'h7fff, 16'h8000, 16'h8000,
                          16'h8000, 16'h7fff, 16'h7fff, 16'h8000});
        pair_q.push_back({16'h7fff, 16'h8000, 16'h8000, 16'h7fff,
                          16'h7fff, 16'h7fff, 16'h8000, 16'h8000});
        pair_q.push_back({16'd10, 16'd10, 16'd0, 16'd0, 16'd10, 16'd10, 16'd0, 16'd0});
        pair_q.push_back({16'd11, 16'd10, 16'd1, 16'd0, 16'd10, 16'd10, 16'd0, 16'd0});
        pair_q.push_back({16'd20, 16'd20, 16'd5, 16'd5, 16'd10, 16'd10, 16'd0, 16'd0});
        pair_q.push_back({16'd0, 16'd20, 16'd0, 16'd10, 16'd10, 16'd10, 16'd0, 16'd0});
        pair_q.push_back({16'd10, 16'd0, 16'd0, 16'd10, 16'd10, 16'd10, 16'd0, 16'd0});
        pair_q.push_back({16'd0, 16'd0, 16'd10, 16'd0, 16'd10, 16'd10, 16'd0, 16'd0});
        pair_q.push_back({16'd1, 16'd0, 16'd0, 16'd3, 16'd1, 16'd3, 16'd0, 16'd0});
        pair_q.push_back({-16'sd7, 16'd5, 16'd3, -16'sd2, 16'd9, -16'sd4, -16'sd1, 16'd6});
        pair_q.push_back({16'd0, 16'd0, 16'd0, 16'd0, 16'd5, 16'd5, 16'd0, 16'd0});
        pair_q.push_back({16'd100, 16'd0, 16'd0, 16'd1, 16'd0, 16'd0, 16'd0, 16'd0});
        foreach (pair_q[i]) send_pair(pair_q[i]);
        wait_drained();

        // fill the pipe while the output holds off
        hold_off <= 1'b1;
        fork
            begin
                repeat (200) @(posedge clk);
                hold_off <= 1'b0;
            end
            for (int i = 0; i < 60; i++) send_pair(crossing_pair());
        join
        wait_drained();

        while (n_sent < 800) begin
            int burst;
            burst = $urandom_range(1, 30);
            for (int i = 0; i < burst; i++) begin
                if ($urandom_range(0, 3) != 0) send_pair(crossing_pair());
                else send_pair(random_pair());
            end
            if ($urandom_range(0, 2) == 0) send_gap();
            if ($urandom_range(0, 40) == 0) wait_drained();
        end
        wait_drained();
        repeat (60) @(posedge clk);
        $display("covered %0d segment pairs, %0d hits, with bursts, gaps and output stalls",
                 sb.n_checked, sb.n_hits);
        if (sb.n_errors == 0 && sb.exp_hit_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

`default_nettype wire

// File: segment_intersection_2d_top.f
hdl/segint_pkg.sv
hdl/segint_front.sv
hdl/segint_div_cell.sv
hdl/segint_back.sv
hdl/segment_intersection_2d_top.sv
hdl/segint_chk.sv
test/tb_segment_intersection_2d_top.sv
